// ===== hdl/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared types and constants of the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int HASH_W  = 32;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 7;
    localparam int LOAD_W  = 7;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [LOAD_W-1:0] LOAD_RESET   = 7'd75;
    localparam logic [LOAD_W-1:0] PERCENT_FULL = 7'd100;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [HASH_W-1:0] hash;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
        logic [CNT_W-1:0]  entry_count;
    } t_result;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FIND_RD,
        BK_FIND_CHK,
        BK_INS_RD,
        BK_INS_CHK,
        BK_DEL_RD,
        BK_DEL_CHK,
        BK_DONE
    } t_back_state;

endpackage

// ===== hdl/rhh_front.sv =====
// ----------------------------------------------------------------------------
// rhh_front
// Accepts operations, trims the key and hashes it one byte per cycle.
// ----------------------------------------------------------------------------
module rhh_front #(
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_enable,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rhh_pkg::FUNC_W-1:0]  i_func,
    input  logic [rhh_pkg::KEY_W-1:0]   i_key,
    input  logic [rhh_pkg::VAL_W-1:0]   i_value,
    output logic                        o_push,
    input  logic                        i_full,
    output rhh_pkg::t_req               o_req
);

    localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [BW-1:0] LAST_BYTE = BW'(KEY_BYTES - 1);

    rhh_pkg::t_front_state r_state, n_state;
    logic [rhh_pkg::FUNC_W-1:0] r_func;
    logic [rhh_pkg::KEY_W-1:0]  r_key, r_kept, n_kept;
    logic [rhh_pkg::VAL_W-1:0]  r_value;
    logic [rhh_pkg::HASH_W-1:0] r_hash, n_hash;
    logic                       r_live, n_live;
    logic [BW-1:0]              r_byte;
    logic [7:0]                 w_byte;
    logic                       w_take;

    assign w_byte = r_key[8*r_byte +: 8];
    assign w_take = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rhh_pkg::FR_IDLE: if (w_take) n_state = rhh_pkg::FR_HASH;
            rhh_pkg::FR_HASH: if (r_byte == LAST_BYTE) n_state = rhh_pkg::FR_PUSH;
            rhh_pkg::FR_PUSH: if (!i_full) n_state = rhh_pkg::FR_IDLE;
            default: n_state = rhh_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == rhh_pkg::FR_IDLE) && i_enable;
        o_push  = (r_state == rhh_pkg::FR_PUSH) && !i_full;
        o_req   = '{func: r_func, key: r_kept, value: r_value, hash: r_hash};
        n_hash  = r_hash;
        n_kept  = r_kept;
        n_live  = r_live;
        // stop at the first zero byte
        if (r_live && (w_byte != 8'd0)) begin
            n_hash = (r_hash ^ {24'd0, w_byte}) * rhh_pkg::FNV_PRIME;
            n_kept[8*r_byte +: 8] = w_byte;
        end else begin
            n_live = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rhh_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
            r_hash  <= rhh_pkg::FNV_BASIS;
            r_kept  <= '0;
            r_live  <= 1'b1;
            r_byte  <= '0;
        end else if (r_state == rhh_pkg::FR_HASH) begin
            r_hash  <= n_hash;
            r_kept  <= n_kept;
            r_live  <= n_live;
            r_byte  <= r_byte + BW'(1);
        end
    end

endmodule

// ===== hdl/rhh_queue.sv =====
// ----------------------------------------------------------------------------
// rhh_queue
// Short FIFO of hashed requests between front and back.
// ----------------------------------------------------------------------------
module rhh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rhh_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output rhh_pkg::t_req o_req
);

    localparam int DEPTH = rhh_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rhh_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_req;
    end

endmodule

// ===== hdl/rhh_back.sv =====
// ----------------------------------------------------------------------------
// rhh_back
// Slot memory and probe sequencer: find, Robin Hood insert, backward shift.
// ----------------------------------------------------------------------------
module rhh_back #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rhh_pkg::LOAD_W-1:0]  i_load_percent,
    input  logic                        i_q_valid,
    input  rhh_pkg::t_req               i_q_req,
    output logic                        o_q_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output rhh_pkg::t_result            o_res,
    output logic                        o_cleared
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int DW = IW + 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int PW = CW + 8;

    typedef struct packed {
        logic                       valid;
        logic [IW-1:0]              pdist;
        logic [rhh_pkg::HASH_W-1:0] hash;
        logic [rhh_pkg::VAL_W-1:0]  value;
        logic [rhh_pkg::KEY_W-1:0]  key;
    } t_entry;

    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rdata, w_wdata;
    logic   w_we;
    logic [IW-1:0] w_waddr;

    rhh_pkg::t_back_state r_state, n_state;
    rhh_pkg::t_req r_req, n_req;
    logic [IW-1:0] r_idx, n_idx, r_empty, n_empty;
    logic [DW-1:0] r_dist, n_dist, r_step, n_step;
    logic [CW-1:0] r_keys, n_keys;
    logic [rhh_pkg::STAT_W-1:0] r_status, n_status;
    logic [rhh_pkg::VAL_W-1:0]  r_found, n_found;
    logic r_res_valid;
    rhh_pkg::t_result r_res;

    logic w_stop, w_match, w_full, w_del_stop;
    logic [rhh_pkg::LOAD_W-1:0] w_lp;
    logic [PW-1:0] w_need, w_room;

    assign w_match = r_rdata.valid && (r_rdata.hash == r_req.hash)
                     && (r_rdata.key == r_req.key);
    assign w_stop  = !r_rdata.valid || (r_dist > {1'b0, r_rdata.pdist});
    assign w_lp    = (i_load_percent > rhh_pkg::PERCENT_FULL)
                     ? rhh_pkg::PERCENT_FULL : i_load_percent;
    assign w_need  = (PW'(r_keys) + PW'(1)) * PW'(rhh_pkg::PERCENT_FULL);
    assign w_room  = PW'(TABLE_SLOTS) * PW'(w_lp);
    assign w_full  = (w_need > w_room) || (r_keys >= CW'(TABLE_SLOTS));
    assign w_del_stop = (r_step + DW'(1) >= DW'(TABLE_SLOTS)) || !r_rdata.valid
                        || (r_rdata.pdist == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rhh_pkg::BK_CLEAR: begin
                if (r_step == DW'(TABLE_SLOTS - 1)) n_state = rhh_pkg::BK_IDLE;
            end
            rhh_pkg::BK_IDLE:     if (i_q_valid) n_state = rhh_pkg::BK_FIND_RD;
            rhh_pkg::BK_FIND_RD:  n_state = rhh_pkg::BK_FIND_CHK;
            rhh_pkg::BK_FIND_CHK: begin
                if (!w_stop && w_match) begin
                    n_state = (r_req.func == rhh_pkg::FUNC_REMOVE)
                              ? rhh_pkg::BK_DEL_RD : rhh_pkg::BK_DONE;
                end else if (!w_stop && (r_dist + DW'(1) != DW'(TABLE_SLOTS))) begin
                    n_state = rhh_pkg::BK_FIND_RD;
                end else if ((r_req.func == rhh_pkg::FUNC_SET) && !w_full) begin
                    n_state = rhh_pkg::BK_INS_RD;
                end else begin
                    n_state = rhh_pkg::BK_DONE;
                end
            end
            rhh_pkg::BK_INS_RD:   n_state = rhh_pkg::BK_INS_CHK;
            rhh_pkg::BK_INS_CHK: begin
                n_state = r_rdata.valid ? rhh_pkg::BK_INS_RD : rhh_pkg::BK_DONE;
            end
            rhh_pkg::BK_DEL_RD:   n_state = rhh_pkg::BK_DEL_CHK;
            rhh_pkg::BK_DEL_CHK: begin
                n_state = w_del_stop ? rhh_pkg::BK_DONE : rhh_pkg::BK_DEL_RD;
            end
            rhh_pkg::BK_DONE: begin
                if (!r_res_valid || i_res_ready) n_state = rhh_pkg::BK_IDLE;
            end
            default:     n_state = rhh_pkg::BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req    = r_req;
        n_idx    = r_idx;
        n_empty  = r_empty;
        n_dist   = r_dist;
        n_step   = r_step;
        n_keys   = r_keys;
        n_status = r_status;
        n_found  = r_found;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = r_rdata;
        o_q_pop  = 1'b0;
        case (r_state)
            rhh_pkg::BK_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_step[IW-1:0];
                w_wdata = '0;
                n_step  = r_step + DW'(1);
            end
            rhh_pkg::BK_IDLE: begin
                o_q_pop = i_q_valid;
                n_req   = i_q_req;
                n_idx   = i_q_req.hash[IW-1:0];
                n_dist  = '0;
                n_found = '0;
            end
            rhh_pkg::BK_FIND_CHK: begin
                if (!w_stop && w_match) begin
                    if (r_req.func == rhh_pkg::FUNC_SET) begin
                        w_we          = 1'b1;
                        w_wdata.value = r_req.value;
                        n_status      = rhh_pkg::ST_REPLACED;
                    end else if (r_req.func == rhh_pkg::FUNC_REMOVE) begin
                        n_found  = r_rdata.value;
                        n_empty  = r_idx;
                        n_idx    = r_idx + IW'(1);
                        n_step   = '0;
                        n_status = rhh_pkg::ST_FOUND;
                    end else begin
                        n_found  = r_rdata.value;
                        n_status = rhh_pkg::ST_FOUND;
                    end
                end else if (!w_stop && (r_dist + DW'(1) != DW'(TABLE_SLOTS))) begin
                    n_idx  = r_idx + IW'(1);
                    n_dist = r_dist + DW'(1);
                end else if (r_req.func == rhh_pkg::FUNC_SET) begin
                    n_status = w_full ? rhh_pkg::ST_FULL : rhh_pkg::ST_INSERTED;
                    n_idx    = r_req.hash[IW-1:0];
                    n_dist   = '0;
                end else begin
                    n_status = rhh_pkg::ST_MISSING;
                end
            end
            rhh_pkg::BK_INS_CHK: begin
                w_we    = 1'b1;
                w_wdata = '{valid: 1'b1, pdist: r_dist[IW-1:0], hash: r_req.hash,
                            value: r_req.value, key: r_req.key};
                if (!r_rdata.valid) begin
                    n_keys = r_keys + CW'(1);
                end else if (r_dist > {1'b0, r_rdata.pdist}) begin
                    // swap with the richer entry and carry it on
                    n_req.key   = r_rdata.key;
                    n_req.value = r_rdata.value;
                    n_req.hash  = r_rdata.hash;
                    n_dist      = {1'b0, r_rdata.pdist} + DW'(1);
                    n_idx       = r_idx + IW'(1);
                end else begin
                    w_we   = 1'b0;
                    n_dist = r_dist + DW'(1);
                    n_idx  = r_idx + IW'(1);
                end
            end
            rhh_pkg::BK_DEL_CHK: begin
                w_we    = 1'b1;
                w_waddr = r_empty;
                if (w_del_stop) begin
                    w_wdata = '0;
                    n_keys  = r_keys - CW'(1);
                end else begin
                    w_wdata.pdist = r_rdata.pdist - IW'(1);
                    n_empty = r_idx;
                    n_idx   = r_idx + IW'(1);
                    n_step  = r_step + DW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rhh_pkg::BK_CLEAR;
            r_step      <= '0;
            r_keys      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_keys  <= n_keys;
            if ((r_state == rhh_pkg::BK_DONE) && (!r_res_valid || i_res_ready)) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_empty  <= n_empty;
        r_dist   <= n_dist;
        r_status <= n_status;
        r_found  <= n_found;
        if ((r_state == rhh_pkg::BK_DONE) && (!r_res_valid || i_res_ready)) begin
            r_res <= '{status: r_status, found_value: r_found,
                       entry_count: rhh_pkg::CNT_W'(r_keys)};
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cleared   = (r_state != rhh_pkg::BK_CLEAR);

endmodule

// ===== hdl/robin_hood_hash_table.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Fixed-size key/value table, FNV-1a hashing, Robin Hood probing.
//
//   channel  | dir | fields
//   s_axis   | in  | tdata: func[1:0] key[65:2] value[97:66]
//   m_axis   | out | tdata: status[2:0] found_value[34:3] entry_count[41:35]
//   cfg      | in  | i_cfg_we, i_cfg_wdata = load_percent
//
// Front hashes one key byte per cycle and takes a new item only once the
// last one is pushed. Back reads, then checks, each probed or shifted
// slot (one memory read port), one item at a time. After reset the slot
// memory is cleared, one slot a cycle, with s_axis_tready low until done.
// A stalled m_axis holds the back and, once the queue fills, the front.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
    parameter int TABLE_SLOTS = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // func[1:0], key[65:2], value[97:66], zero fill
    input  logic [rhh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[2:0], found_value[34:3], entry_count[41:35], zero fill
    output logic [rhh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [rhh_pkg::LOAD_W-1:0]         i_cfg_wdata
);

    logic [rhh_pkg::LOAD_W-1:0] r_load_percent;
    logic w_push, w_full, w_q_valid, w_pop, w_cleared;
    rhh_pkg::t_req    w_front_req, w_q_req;
    rhh_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_percent <= rhh_pkg::LOAD_RESET;
        end else if (i_cfg_we) begin
            r_load_percent <= i_cfg_wdata;
        end
    end

    rhh_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (w_cleared),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tdata[1:0]),
        .i_key    (s_axis_tdata[65:2]),
        .i_value  (s_axis_tdata[97:66]),
        .o_push   (w_push),
        .i_full   (w_full),
        .o_req    (w_front_req)
    );

    rhh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_front_req),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_req   (w_q_req)
    );

    rhh_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load_percent (r_load_percent),
        .i_q_valid      (w_q_valid),
        .i_q_req        (w_q_req),
        .o_q_pop        (w_pop),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_res          (w_res),
        .o_cleared      (w_cleared)
    );

    assign m_axis_tdata = {6'd0, w_res.entry_count, w_res.found_value, w_res.status};

endmodule

// ===== hdl/rhh_checker.sv =====
// ----------------------------------------------------------------------------
// rhh_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module rhh_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rhh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // memory clear runs right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken during memory clear");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= rhh_pkg::ST_FULL))
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] != rhh_pkg::ST_FOUND))
        |-> (m_axis_tdata[34:3] == '0))
        else $error("found_value set without a hit");

    a_count_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == rhh_pkg::ST_INSERTED))
        |-> (m_axis_tdata[41:35] != '0))
        else $error("insert left the table empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output transfer changed");

endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/rhh_table_checker.sv =====
// ----------------------------------------------------------------------------
// rhh_table_checker
// Watches both stream channels and the config port of the hash table. It
// keeps its own copy of the slot array and applies every accepted request to
// it: FNV-1a over the trimmed key, Robin Hood insert and backward-shift
// delete. Each accepted response is compared field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module rhh_table_checker
    import rhh_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int KEYB  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [LOAD_W-1:0]      i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bit                slot_used [SLOTS];
    logic [KEY_W-1:0]  slot_key  [SLOTS];
    logic [VAL_W-1:0]  slot_val  [SLOTS];
    logic [HASH_W-1:0] slot_hash [SLOTS];
    int                slot_dist [SLOTS];
    int                keys_held;
    int                load_pct;
    t_result           expected_results[$];
    int                errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    function automatic int next_idx(input int i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // Keep the bytes before the first zero byte and hash them.
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k,
                                                  output logic [HASH_W-1:0] h);
        logic [KEY_W-1:0] kept;
        logic [7:0]       b;
        kept = '0;
        h    = FNV_BASIS;
        for (int i = 0; i < KEYB; i++) begin
            b = k[8*i +: 8];
            if (b == 8'd0) break;
            kept[8*i +: 8] = b;
            h = (h ^ {24'd0, b}) * FNV_PRIME;
        end
        return kept;
    endfunction

    function automatic bit lookup(input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h,
                                  output int where);
        int idx;
        idx   = int'(h) & (SLOTS - 1);
        where = 0;
        for (int d = 0; d < SLOTS; d++) begin
            if (!slot_used[idx] || d > slot_dist[idx]) return 0;
            if (slot_hash[idx] == h && slot_key[idx] == k) begin
                where = idx;
                return 1;
            end
            idx = next_idx(idx);
        end
        return 0;
    endfunction

    function automatic void place_key(input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v,
                                      input logic [HASH_W-1:0] h);
        int                idx;
        int                d;
        int                td;
        logic [KEY_W-1:0]  tk;
        logic [VAL_W-1:0]  tv;
        logic [HASH_W-1:0] th;
        idx = int'(h) & (SLOTS - 1);
        d   = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_used[idx]) begin
                slot_used[idx] = 1;
                slot_key[idx]  = k;
                slot_val[idx]  = v;
                slot_hash[idx] = h;
                slot_dist[idx] = d;
                return;
            end
            // swap with an entry that sits closer to its home slot
            if (d > slot_dist[idx]) begin
                tk = slot_key[idx];  tv = slot_val[idx];
                th = slot_hash[idx]; td = slot_dist[idx];
                slot_key[idx]  = k; slot_val[idx]  = v;
                slot_hash[idx] = h; slot_dist[idx] = d;
                k = tk; v = tv; h = th; d = td;
            end
            d++;
            idx = next_idx(idx);
        end
    endfunction

    function automatic void drop_slot(input int idx);
        int gap;
        int nxt;
        gap = idx;
        nxt = next_idx(idx);
        for (int s = 0; s + 1 < SLOTS; s++) begin
            if (!slot_used[nxt] || slot_dist[nxt] == 0) break;
            slot_key[gap]  = slot_key[nxt];
            slot_val[gap]  = slot_val[nxt];
            slot_hash[gap] = slot_hash[nxt];
            slot_dist[gap] = slot_dist[nxt] - 1;
            gap = nxt;
            nxt = next_idx(nxt);
        end
        slot_used[gap] = 0;
    endfunction

    function automatic t_result table_apply(input logic [FUNC_W-1:0] func,
                                            input logic [KEY_W-1:0] key_in,
                                            input logic [VAL_W-1:0] value);
        t_result           r;
        logic [HASH_W-1:0] h;
        logic [KEY_W-1:0]  k;
        int                where;
        int                pct;
        bit                hit;
        k   = trim_key(key_in, h);
        hit = lookup(k, h, where);
        r   = '0;
        if (func == FUNC_SET) begin
            if (hit) begin
                slot_val[where] = value;
                r.status = ST_REPLACED;
            end else begin
                pct = (load_pct > 100) ? 100 : load_pct;
                if ((keys_held + 1) * 100 > SLOTS * pct || keys_held >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    place_key(k, value, h);
                    keys_held++;
                    r.status = ST_INSERTED;
                end
            end
        end else if (func == FUNC_REMOVE) begin
            if (hit) begin
                r.found_value = slot_val[where];
                drop_slot(where);
                if (keys_held > 0) keys_held--;
                r.status = ST_FOUND;
            end else begin
                r.status = ST_MISSING;
            end
        end else begin
            if (hit) begin
                r.found_value = slot_val[where];
                r.status = ST_FOUND;
            end else begin
                r.status = ST_MISSING;
            end
        end
        r.entry_count = CNT_W'(keys_held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 0;
            keys_held = 0;
            load_pct  = int'(LOAD_RESET);
            errors    = 0;
            expected_results.delete();
        end else begin
            // check responses first: a request accepted now cannot answer now
            if (m_axis_tvalid && m_axis_tready) begin
                got.status      = m_axis_tdata[2:0];
                got.found_value = m_axis_tdata[34:3];
                got.entry_count = m_axis_tdata[41:35];
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%t unexpected response: status %0d value %h count %0d",
                                 $realtime, got.status, got.found_value, got.entry_count);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%t response mismatch: expected status %0d value %h ",
                                      "count %0d, got status %0d value %h count %0d"},
                                     $realtime, want.status, want.found_value,
                                     want.entry_count, got.status, got.found_value,
                                     got.entry_count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(table_apply(s_axis_tdata[1:0],
                                                       s_axis_tdata[65:2],
                                                       s_axis_tdata[97:66]));
            if (i_cfg_we) load_pct = int'(i_cfg_wdata);
        end
    end

endmodule

// ===== tb/sv/tb_robin_hood_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_table
// Stimulus for the hash table: a directed opening, then random set, get,
// remove and spare-code requests drawn mostly from a pool of keys (with junk behind the key
// terminator) under several load limits, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_robin_hood_hash_table;
    import rhh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int POOL_SIZE = 96;
    localparam int PHASE_ITEMS = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [LOAD_W-1:0]      i_cfg_wdata = '0;
    int                     mismatches;
    int                     pending;
    bit                     no_gaps;
    logic [KEY_W-1:0]       key_pool [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    robin_hood_hash_table dut (.*);

    rhh_table_checker checker_i (.o_errors(mismatches), .o_pending(pending), .*);

    task automatic send_req(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, value, key, func};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // wait for the table to drain, then write the load limit
    task automatic set_load(input logic [LOAD_W-1:0] pct);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pct;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // pool key, sometimes with junk after the terminating zero byte
    function automatic logic [KEY_W-1:0] pool_key(input int i);
        logic [KEY_W-1:0] k;
        int len;
        k = key_pool[i];
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'd0) len++;
        if (len < 7 && $urandom_range(0, 2) == 0)
            for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom);
        return k;
    endfunction

    initial begin
        logic [LOAD_W-1:0] loads [6] = '{7'd100, 7'd127, 7'd0, 7'd1, 7'd50, 7'd75};
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        int                len;
        int                pick;

        foreach (key_pool[i]) begin
            key_pool[i] = '0;
            len = (i == 0) ? 0 : $urandom_range(1, 8);
            for (int b = 0; b < len; b++) key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
        end
        no_gaps = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening under the reset load limit
        send_req(FUNC_SET, 64'd0, 32'hFFFF_FFFF);               // empty key
        send_req(FUNC_GET, 64'hFFFF_FFFF_FFFF_FF00, 32'd0);     // empty key, junk after
        send_req(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_req(FUNC_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
        send_req(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);  // replace
        send_req(FUNC_SET, 64'h0000_0000_0000_0041, 32'd1);
        send_req(FUNC_GET, 64'h1234_0000_0000_0041, 32'd7);     // same key after trim
        send_req(FUNC_REMOVE, 64'h0000_0000_0000_0042, 32'd0);  // missing
        send_req(FUNC_REMOVE, 64'h0000_0000_0000_0041, 32'd0);
        send_req(FUNC_GET, 64'h0000_0000_0000_0041, 32'd0);
        send_req(FUNC_REMOVE, 64'd0, 32'd0);
        send_req(FUNC_GET, 64'd0, 32'd0);
        send_req(FUNC_SPARE, 64'h0000_0000_0000_7F01, 32'd0);

        foreach (loads[p]) begin
            set_load(loads[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                func = (pick < 50) ? FUNC_SET : (pick < 72) ? FUNC_GET :
                       (pick < 95) ? FUNC_REMOVE : FUNC_SPARE;
                if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
                else key = pool_key($urandom_range(0, POOL_SIZE - 1));
                send_req(func, key, $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // response side: random stalls, with stretches of none
    initial begin
        int stall;
        int count;
        count = 0;
        forever begin
            stall = ((count / 32) % 4 == 3) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            count++;
        end
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
